// File: rtl/assert_macros.svh
// ---------------------------------------------------------------------------
// assert_macros.svh
// assertion helpers shared by the rtl of the shelf allocator
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked out of reset
`define SRA_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked out of reset
`define SRA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/sra_pkg.sv
// ---------------------------------------------------------------------------
// sra_pkg
// types and constants of the shelf rectangle allocator
// ---------------------------------------------------------------------------
package sra_pkg;

    // field widths
    localparam int unsigned REQ_W   = 12;
    localparam int unsigned TEX_W   = 13;
    localparam int unsigned POS_W   = 12;
    localparam int unsigned CFG_IDX_W = 1;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_TEX_WIDTH  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TEX_HEIGHT = 1'd1;

    // reset values
    localparam logic [TEX_W-1:0] TEX_SIZE_RST  = 13'd128;
    localparam logic [TEX_W-1:0] FREE_Y_RST    = 13'd3;

    // floor(h/10) for 12-bit h: (h * 3277) >> 15 is exact below 16384
    localparam logic [11:0] DIV10_RECIP = 12'd3277;
    localparam int unsigned DIV10_SHIFT = 15;

    // one shelf entry as held in memory
    typedef struct packed {
        logic [POS_W-1:0] top;
        logic [TEX_W-1:0] height;
        logic [TEX_W-1:0] used;
    } t_shelf;

endpackage

// File: rtl/sra_shelf_ram.sv
// ---------------------------------------------------------------------------
// sra_shelf_ram
// shelf table: one write port, one read port, registered read data
// ---------------------------------------------------------------------------
module sra_shelf_ram
    import sra_pkg::*;
#(
    parameter int unsigned DEPTH  = 32,
    parameter int unsigned ADDR_W = 5
) (
    input  logic              i_clk,
    input  logic              i_rd_en,
    input  logic [ADDR_W-1:0] i_rd_addr,
    output t_shelf            o_rd_data,
    input  logic              i_wr_en,
    input  logic [ADDR_W-1:0] i_wr_addr,
    input  t_shelf            i_wr_data
);

    t_shelf r_mem [DEPTH];
    t_shelf r_rd_data;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // read port, read data registered while the read enable is high
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// File: rtl/sra_fit_check.sv
// ---------------------------------------------------------------------------
// sra_fit_check
// fit test of one shelf and best-fit choice against the current best
// ---------------------------------------------------------------------------
module sra_fit_check
    import sra_pkg::*;
(
    input  logic [REQ_W-1:0] i_req_width,
    input  logic [REQ_W-1:0] i_req_height,
    input  logic [TEX_W-1:0] i_tex_width,
    input  t_shelf           i_shelf,
    input  logic             i_found,
    input  logic [TEX_W-1:0] i_best_height,
    output logic             o_take
);

    logic [15:0] h_x10;
    logic [15:0] sh_x7;
    logic [13:0] need_w;
    logic        fits;

    // height band: 10*h >= 7*H and h <= H
    assign h_x10  = 16'(i_req_height) * 16'd10;
    assign sh_x7  = 16'(i_shelf.height) * 16'd7;
    // width taken on the shelf once the request is placed
    assign need_w = 14'(i_req_width) + 14'(i_shelf.used);

    assign fits = (h_x10 >= sh_x7) && (13'(i_req_height) <= i_shelf.height)
               && (need_w <= 14'(i_tex_width));

    // smallest height wins, later shelf on a tie
    assign o_take = fits && (!i_found || (i_shelf.height <= i_best_height));

endmodule

// File: rtl/shelf_rect_allocator_core.sv
// ---------------------------------------------------------------------------
// shelf_rect_allocator_core
// shelf best-fit rectangle allocator for a texture atlas
//
// A request is taken at a clock edge with start high and busy low; busy then
// stays high until the request is done. The shelf table is scanned one shelf
// per cycle through the read port of the shelf memory. One result per request
// appears on o_rect_x, o_rect_y and o_granted for exactly one cycle with
// o_valid high; the receiver cannot stall it. A new request may be started in
// the cycle the result is shown, but not before the previous request is done.
// Configuration writes (texture width, height) use i_cfg_valid/o_cfg_ready;
// o_cfg_ready is always high, and writes are to be made only while the block is
// idle; the block itself does not enforce this.
// Synchronous active-low reset empties the shelf table (count zero), sets the
// next free row to 3 and both texture sizes to 128. The shelf memory is not
// cleared: only entries below the shelf count are ever read.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module shelf_rect_allocator_core
    import sra_pkg::*;
#(
    parameter int unsigned MAX_SHELVES = 32
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // request
    input  logic                 start,
    output logic                 busy,
    input  logic [REQ_W-1:0]     i_req_width,
    input  logic [REQ_W-1:0]     i_req_height,
    // result
    output logic                 o_valid,
    output logic [POS_W-1:0]     o_rect_x,
    output logic [POS_W-1:0]     o_rect_y,
    output logic                 o_granted,
    // configuration
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [TEX_W-1:0]     i_cfg_data
);

    localparam int unsigned CNT_W  = $clog2(MAX_SHELVES + 1);
    localparam int unsigned ADDR_W = (MAX_SHELVES > 1) ? $clog2(MAX_SHELVES) : 1;
    localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_SHELVES);

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_SCAN   = 2'd1;
    localparam logic [1:0] ST_FINISH = 2'd2;

    // control state
    logic [1:0]        r_state, n_state;
    logic [CNT_W-1:0]  r_count, n_count;
    logic [TEX_W-1:0]  r_free_y, n_free_y;
    logic [TEX_W-1:0]  r_tex_w, r_tex_h;
    logic [CNT_W-1:0]  r_idx, n_idx;
    logic              r_pend, n_pend;
    logic              r_found, n_found;
    logic              r_valid, n_valid;

    // payload
    logic [REQ_W-1:0]  r_w, r_h;
    logic [TEX_W-1:0]  r_rh;
    logic [ADDR_W-1:0] r_pidx;
    logic [ADDR_W-1:0] r_best, n_best;
    t_shelf            r_best_ent, n_best_ent;
    logic [POS_W-1:0]  r_x, n_x, r_y, n_y;
    logic              r_granted, n_granted;

    // memory ports
    logic              rd_en;
    t_shelf            rd_data;
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    t_shelf            wr_data;

    logic              take;
    logic              accept;
    logic [26:0]       h_prod;
    logic [13:0]       new_end;
    logic              refuse;

    assign accept      = start && (r_state == ST_IDLE);
    assign busy        = (r_state != ST_IDLE);
    assign o_cfg_ready = 1'b1;
    assign rd_en       = (r_state == ST_SCAN) && (r_idx < r_count);

    sra_shelf_ram #(
        .DEPTH  (MAX_SHELVES),
        .ADDR_W (ADDR_W)
    ) u_ram (
        .i_clk     (i_clk),
        .i_rd_en   (rd_en),
        .i_rd_addr (r_idx[ADDR_W-1:0]),
        .o_rd_data (rd_data),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data)
    );

    sra_fit_check u_fit (
        .i_req_width   (r_w),
        .i_req_height  (r_h),
        .i_tex_width   (r_tex_w),
        .i_shelf       (rd_data),
        .i_found       (r_found),
        .i_best_height (r_best_ent.height),
        .o_take        (take)
    );

    // new shelf height h + h/10
    assign h_prod  = 27'(r_h) * 27'(DIV10_RECIP);
    // refusal test of a new shelf
    assign new_end = 14'(r_free_y) + 14'(r_rh);
    assign refuse  = (new_end >= 14'(r_tex_h)) || (13'(r_w) >= r_tex_w)
                  || (r_count >= MAX_CNT);

    // sequencer
    always_comb begin
        n_state    = r_state;
        n_count    = r_count;
        n_free_y   = r_free_y;
        n_idx      = r_idx;
        n_pend     = r_pend;
        n_found    = r_found;
        n_valid    = 1'b0;
        n_best     = r_best;
        n_best_ent = r_best_ent;
        n_x        = r_x;
        n_y        = r_y;
        n_granted  = r_granted;
        wr_en      = 1'b0;
        wr_addr    = r_best;
        wr_data    = r_best_ent;
        unique case (r_state)
            ST_IDLE: begin
                if (start) begin
                    n_state = ST_SCAN;
                    n_idx   = '0;
                    n_pend  = 1'b0;
                    n_found = 1'b0;
                end
            end
            ST_SCAN: begin
                n_pend = rd_en;
                if (rd_en) begin
                    n_idx = r_idx + 1'b1;
                end
                // judge the shelf read last cycle
                if (r_pend && take) begin
                    n_found    = 1'b1;
                    n_best     = r_pidx;
                    n_best_ent = rd_data;
                end
                if (!rd_en) begin
                    n_state = ST_FINISH;
                end
            end
            ST_FINISH: begin
                n_state = ST_IDLE;
                n_valid = 1'b1;
                if (r_found) begin
                    n_x         = r_best_ent.used[POS_W-1:0];
                    n_y         = r_best_ent.top;
                    n_granted   = 1'b1;
                    wr_en       = 1'b1;
                    wr_data.used = r_best_ent.used + 13'(r_w);
                end else if (refuse) begin
                    n_x       = '0;
                    n_y       = '0;
                    n_granted = 1'b0;
                end else begin
                    n_x            = '0;
                    n_y            = r_free_y[POS_W-1:0];
                    n_granted      = 1'b1;
                    wr_en          = 1'b1;
                    wr_addr        = r_count[ADDR_W-1:0];
                    wr_data.top    = r_free_y[POS_W-1:0];
                    wr_data.height = r_rh;
                    wr_data.used   = 13'(r_w);
                    n_count        = r_count + 1'b1;
                    n_free_y       = new_end[TEX_W-1:0];
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_count  <= '0;
            r_free_y <= FREE_Y_RST;
            r_tex_w  <= TEX_SIZE_RST;
            r_tex_h  <= TEX_SIZE_RST;
            r_idx    <= '0;
            r_pend   <= 1'b0;
            r_found  <= 1'b0;
            r_valid  <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_free_y <= n_free_y;
            r_idx    <= n_idx;
            r_pend   <= n_pend;
            r_found  <= n_found;
            r_valid  <= n_valid;
            // configuration transaction
            if (i_cfg_valid && o_cfg_ready) begin
                if (i_cfg_index == REG_TEX_WIDTH) begin
                    r_tex_w <= i_cfg_data;
                end else if (i_cfg_index == REG_TEX_HEIGHT) begin
                    r_tex_h <= i_cfg_data;
                end
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_w <= i_req_width;
            r_h <= i_req_height;
        end
        if (r_state == ST_SCAN) begin
            r_rh <= 13'(r_h) + 13'(h_prod[DIV10_SHIFT +: REQ_W]);
        end
        r_pidx     <= r_idx[ADDR_W-1:0];
        r_best     <= n_best;
        r_best_ent <= n_best_ent;
        r_x        <= n_x;
        r_y        <= n_y;
        r_granted  <= n_granted;
    end

    assign o_valid   = r_valid;
    assign o_rect_x  = r_x;
    assign o_rect_y  = r_y;
    assign o_granted = r_granted;

    // checks
    `SRA_ASSERT_NEXT(a_finish_gives_result, i_clk, i_rst_n, r_state == ST_FINISH, o_valid, "finish without result")
    `SRA_ASSERT_SAME(a_count_bound, i_clk, i_rst_n, 1'b1, r_count <= MAX_CNT, "shelf count above limit")
    `SRA_ASSERT_SAME(a_refused_zero, i_clk, i_rst_n, o_valid && !o_granted, (o_rect_x == '0) && (o_rect_y == '0), "refused result not zero")
    `SRA_ASSERT_NEXT(a_accept_busy, i_clk, i_rst_n, start && !busy, busy && !o_valid, "accepted request not busy")

endmodule

// File: tb/tb_shelf_rect_allocator_core.sv
// ---------------------------------------------------------------------------
// tb_shelf_rect_allocator_core
// self-checking bench for the shelf rectangle allocator
//
// Requests go in through the start/busy command port. Each placement the
// block returns is checked field by field against a shelf table kept in the
// bench. The run opens with hand-picked requests at the reset texture size.
// It then steps through several texture sizes, the extremes among them, each
// with a burst of random requests. Most requests are small glyph-like
// rectangles, and heights repeat often so that shelves fill up.
// ---------------------------------------------------------------------------
module tb_shelf_rect_allocator_core;
    import sra_pkg::*;

    localparam int unsigned NUM_SHELVES     = 32;
    localparam int unsigned ITEMS_PER_PHASE = 75;
    localparam int unsigned NUM_PHASES      = 10;
    localparam int unsigned CYCLE_LIMIT     = 400000;

    typedef struct packed {
        logic [POS_W-1:0] x;
        logic [POS_W-1:0] y;
        logic             granted;
    } t_placement;

    // shelf table mirror, placements still owed by the block
    class t_shelf_tracker;
        logic [POS_W-1:0] top    [NUM_SHELVES];
        logic [TEX_W-1:0] height [NUM_SHELVES];
        logic [TEX_W-1:0] used   [NUM_SHELVES];
        int unsigned      count;
        logic [TEX_W-1:0] free_y;
        logic [TEX_W-1:0] tex_w;
        logic [TEX_W-1:0] tex_h;
        t_placement       placements_due[$];
        int unsigned      mismatches;

        function new();
            count      = 0;
            free_y     = FREE_Y_RST;
            tex_w      = TEX_SIZE_RST;
            tex_h      = TEX_SIZE_RST;
            mismatches = 0;
        endfunction

        function int unsigned pending();
            return placements_due.size();
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [TEX_W-1:0] data);
            case (idx)
                REG_TEX_WIDTH:  tex_w = data;
                REG_TEX_HEIGHT: tex_h = data;
                default: ;
            endcase
        endfunction

        // best fit over open shelves, otherwise open a new one
        function void note_request(logic [REQ_W-1:0] req_w, logic [REQ_W-1:0] req_h);
            int unsigned w;
            int unsigned h;
            int unsigned sh;
            int unsigned best;
            int unsigned best_h;
            int unsigned rh;
            int unsigned sum;
            bit          found;
            t_placement  p;
            w      = req_w;
            h      = req_h;
            best   = 0;
            best_h = 0;
            found  = 1'b0;
            for (int i = 0; i < int'(count); i++) begin
                sh = height[i];
                if (10 * h >= 7 * sh && h <= sh && w + used[i] <= tex_w &&
                    !(found && sh > best_h)) begin
                    found  = 1'b1;
                    best   = i;
                    best_h = sh;
                end
            end
            if (!found) begin
                rh = h + h / 10;
                if (free_y + rh >= tex_h || w >= tex_w || count >= NUM_SHELVES) begin
                    p = '0;
                    placements_due.push_back(p);
                    return;
                end
                best         = count;
                top[best]    = free_y[POS_W-1:0];
                height[best] = rh[TEX_W-1:0];
                used[best]   = '0;
                count        = count + 1;
                sum          = free_y + rh;
                free_y       = sum[TEX_W-1:0];
            end
            p.x       = used[best][POS_W-1:0];
            p.y       = top[best];
            p.granted = 1'b1;
            placements_due.push_back(p);
            sum        = used[best] + w;
            used[best] = sum[TEX_W-1:0];
        endfunction

        function void check_placement(logic [POS_W-1:0] x, logic [POS_W-1:0] y, logic g);
            t_placement want;
            if (placements_due.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected placement: x=%0d y=%0d granted=%0b", x, y, g);
                return;
            end
            want = placements_due.pop_front();
            if (x !== want.x || y !== want.y || g !== want.granted) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("placement mismatch: expected x=%0d y=%0d granted=%0b, got x=%0d y=%0d granted=%0b",
                             want.x, want.y, want.granted, x, y, g);
            end
        endfunction
    endclass

    logic             i_clk        = 1'b0;
    logic             i_rst_n      = 1'b0;
    logic             start        = 1'b0;
    logic [REQ_W-1:0] i_req_width  = '0;
    logic [REQ_W-1:0] i_req_height = '0;
    logic             i_cfg_valid  = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_index = REG_TEX_WIDTH;
    logic [TEX_W-1:0] i_cfg_data   = '0;
    logic             busy;
    logic             o_valid;
    logic [POS_W-1:0] o_rect_x;
    logic [POS_W-1:0] o_rect_y;
    logic             o_granted;
    logic             o_cfg_ready;

    t_shelf_tracker   tracker = new();
    int unsigned      cycles  = 0;
    logic [REQ_W-1:0] last_h  = '0;

    shelf_rect_allocator_core #(
        .MAX_SHELVES (NUM_SHELVES)
    ) u_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .busy         (busy),
        .i_req_width  (i_req_width),
        .i_req_height (i_req_height),
        .o_valid      (o_valid),
        .o_rect_x     (o_rect_x),
        .o_rect_y     (o_rect_y),
        .o_granted    (o_granted),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data)
    );

    // clock
    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // watchdog
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    // transaction monitor: results, accepted requests, register writes
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_valid)
                tracker.check_placement(o_rect_x, o_rect_y, o_granted);
            if (start && !busy)
                tracker.note_request(i_req_width, i_req_height);
            if (i_cfg_valid && o_cfg_ready)
                tracker.write_reg(i_cfg_index, i_cfg_data);
        end
    end

    // one request, after a gap; start stays high when the gap is zero
    task automatic send_request(input logic [REQ_W-1:0] w, input logic [REQ_W-1:0] h,
                                input int unsigned gap);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start        <= 1'b1;
        i_req_width  <= w;
        i_req_height <= h;
        do @(posedge i_clk); while (busy);
    endtask

    // wait until every placement has come back and the block is idle
    task automatic drain();
        start <= 1'b0;
        @(posedge i_clk);
        while (tracker.pending() != 0 || busy) @(posedge i_clk);
    endtask

    task automatic program_texture(input logic [TEX_W-1:0] tw, input logic [TEX_W-1:0] th);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= REG_TEX_WIDTH;
        i_cfg_data  <= tw;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_index <= REG_TEX_HEIGHT;
        i_cfg_data  <= th;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
    endtask

    // mostly glyph-sized, sometimes medium, now and then anything
    function automatic logic [REQ_W-1:0] draw_extent(input int unsigned glyph_max);
        case ($urandom_range(0, 9))
            7, 8:    return REQ_W'($urandom_range(0, 400));
            9:       return REQ_W'($urandom_range(0, 4095));
            default: return REQ_W'($urandom_range(0, glyph_max));
        endcase
    endfunction

    // stimulus
    initial begin
        int unsigned      dir_w [24];
        int unsigned      dir_h [24];
        logic [TEX_W-1:0] tw;
        logic [TEX_W-1:0] th;
        logic [REQ_W-1:0] w;
        logic [REQ_W-1:0] h;
        bit               no_gaps;

        // zero heights, refusals at the edges, ties, full-width shelves
        dir_w = '{0, 5, 0, 4095, 10, 0, 20, 120, 127, 128, 0, 100,
                  100, 10, 4095, 0, 1, 2048, 64, 3, 0, 7, 4095, 50};
        dir_h = '{0, 0, 4095, 10, 10, 8, 7, 11, 5, 5, 0, 20,
                  20, 20, 4095, 1, 100, 2048, 18, 19, 14, 13, 0, 116};

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int i = 0; i < 24; i++)
            send_request(REQ_W'(dir_w[i]), REQ_W'(dir_h[i]), $urandom_range(0, 15));

        for (int p = 0; p < int'(NUM_PHASES); p++) begin
            case (p)
                0: begin tw = 13'd8191; th = 13'd8191; end
                1: begin tw = 13'd4096; th = 13'd4096; end
                2: begin tw = 13'd1;    th = 13'd1;    end
                3: begin tw = 13'd0;    th = 13'd0;    end
                4: begin tw = 13'd4096; th = 13'd128;  end
                5: begin tw = 13'd128;  th = 13'd128;  end
                6: begin tw = TEX_W'($urandom_range(0, 8191)); th = TEX_W'($urandom_range(0, 8191)); end
                default: begin
                    tw = TEX_W'($urandom_range(1, 4096));
                    th = TEX_W'($urandom_range(1, 4096));
                end
            endcase
            drain();
            program_texture(tw, th);
            no_gaps = ($urandom_range(0, 3) == 0);
            for (int n = 0; n < int'(ITEMS_PER_PHASE); n++) begin
                w = draw_extent(48);
                // runs of one height, as glyphs of one font size give
                if ($urandom_range(0, 9) < 4)
                    h = last_h;
                else
                    h = draw_extent(40);
                last_h = h;
                send_request(w, h, no_gaps ? 0 : $urandom_range(0, 15));
            end
        end

        // let the last placements out and give the block time to settle
        drain();
        repeat (NUM_SHELVES + 4) @(posedge i_clk);
        if (tracker.mismatches == 0 && tracker.pending() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
